/* src/ines_rom_header_detector_unit_defines.svh */
// assertion macros shared by the header detector rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef INES_ROM_HEADER_DETECTOR_UNIT_DEFINES_SVH
`define INES_ROM_HEADER_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, quiet while in reset
`define IRHD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irhd assertion failed");

// next-cycle implication, quiet while in reset
`define IRHD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irhd assertion failed");

`endif

/* src/irhd_pkg.sv */
// types and constants of the ines rom header detector
// no dependencies
package irhd_pkg;

    localparam logic [31:0] MAGIC_WORD    = 32'h4E45_531A;
    localparam logic [31:0] MIN_FIRST_LEN = 32'h0000_400F;
    localparam logic [7:0]  FLAG_MASK     = 8'hFE;
    localparam logic [7:0]  PRG_LIMIT     = 8'd129;

    // prg*0x3fff + chr*0x1fff + 15 stays below 2**23
    localparam int unsigned SPAN_W = 23;
    localparam logic [SPAN_W-1:0] PRG_FACTOR = 23'h3FFF;
    localparam logic [SPAN_W-1:0] CHR_FACTOR = 23'h1FFF;
    localparam logic [SPAN_W-1:0] END_EXTRA  = 23'd15;

    // byte offsets from the magic position
    localparam logic [3:0] OFS_MAGIC = 4'd0;
    localparam logic [3:0] OFS_PRG   = 4'd1;
    localparam logic [3:0] OFS_CHR   = 4'd2;
    localparam logic [3:0] OFS_FLAGS = 4'd6;
    localparam logic [3:0] OFS_PAD   = 4'd11;
    localparam logic [3:0] OFS_LAST  = 4'd12;

    localparam logic [1:0] START_BACK = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_FOUND
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_ACCEPT,
        ST_DISABLED
    } status_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] block_pos;
        logic [31:0] block_len;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] rom_start;
        logic [31:0] rom_end;
    } result_t;

    function automatic logic [SPAN_W-1:0] span_calc(input logic [7:0] prg,
                                                    input logic [7:0] chr);
        span_calc = SPAN_W'(prg) * PRG_FACTOR + SPAN_W'(chr) * CHR_FACTOR + END_EXTRA;
    endfunction

endpackage

/* src/irhd_if.sv */
// valid/ready channels of the header detector: input items and results
// depends on irhd_pkg
interface irhd_item_if;
    logic           valid;
    logic           ready;
    irhd_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface irhd_result_if;
    logic             valid;
    logic             ready;
    irhd_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/irhd_in_stage.sv */
// input register of the header detector, holds one item until it is scanned
// depends on irhd_pkg and irhd_if
module irhd_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    irhd_item_if.sink       stream,
    input  logic            advance,
    output logic            item_valid,
    output irhd_pkg::item_t item
);
    import irhd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // a held item leaving this cycle frees the slot for the next
    assign stream.ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (stream.ready)
        begin
            valid_next = stream.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            item_reg <= stream.data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* src/irhd_scan.sv */
// scan state of the header detector: byte window, header phase, positions
// depends on irhd_pkg and the assertion macro header
`include "ines_rom_header_detector_unit_defines.svh"

module irhd_scan #(
    parameter int unsigned POS_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  irhd_pkg::item_t   item,
    output irhd_pkg::result_t result
);
    import irhd_pkg::*;

    logic [31:0]         window_reg,     window_next;
    phase_t              phase_reg,      phase_next;
    logic [POS_BITS-1:0] magic_pos_reg,  magic_pos_next;
    logic [7:0]          prg_reg,        prg_next;
    logic [7:0]          chr_reg,        chr_next;
    logic [POS_BITS-1:0] stream_pos_reg, stream_pos_next;
    logic [POS_BITS-1:0] block_start_reg, block_start_next;
    logic [POS_BITS-1:0] cand_start_reg, cand_start_next;
    logic [SPAN_W-1:0]   span_reg,       span_next;
    logic [POS_BITS-1:0] found_start_reg, found_start_next;
    logic [POS_BITS-1:0] found_end_reg,  found_end_next;

    logic                short_block;
    logic [POS_BITS-1:0] bpos;
    logic                block_change;
    logic [POS_BITS-1:0] pos_now;
    logic [31:0]         window_new;
    logic [POS_BITS-1:0] ofs;
    logic                accepted;

    always_comb
    begin
        window_next      = window_reg;
        phase_next       = phase_reg;
        magic_pos_next   = magic_pos_reg;
        prg_next         = prg_reg;
        chr_next         = chr_reg;
        stream_pos_next  = stream_pos_reg;
        block_start_next = block_start_reg;
        cand_start_next  = cand_start_reg;
        found_start_next = found_start_reg;
        found_end_next   = found_end_reg;
        accepted         = 1'b0;

        short_block  = (item.block_pos == 32'd0) && (item.block_len < MIN_FIRST_LEN);
        bpos         = POS_BITS'(item.block_pos);
        block_change = (bpos != block_start_reg);
        pos_now      = block_change ? bpos : stream_pos_reg;
        window_new   = {window_reg[23:0], item.data_byte};
        ofs          = pos_now - magic_pos_reg;

        if (!short_block)
        begin
            if (block_change)
            begin
                block_start_next = bpos;
            end
            window_next     = window_new;
            stream_pos_next = pos_now + POS_BITS'(1);

            case (phase_reg)
                PH_IDLE:
                begin
                    if (window_new == MAGIC_WORD)
                    begin
                        phase_next      = PH_HEADER;
                        magic_pos_next  = pos_now;
                        prg_next        = 8'd0;
                        cand_start_next = pos_now - POS_BITS'(START_BACK);
                    end
                end
                PH_HEADER:
                begin
                    if (ofs == POS_BITS'(OFS_PRG))
                    begin
                        prg_next = item.data_byte;
                    end
                    else if (ofs == POS_BITS'(OFS_CHR))
                    begin
                        chr_next = item.data_byte;
                    end
                    else if (ofs == POS_BITS'(OFS_FLAGS))
                    begin
                        if ((item.data_byte & FLAG_MASK) != 8'd0)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (ofs == POS_BITS'(OFS_PAD))
                    begin
                        if (window_new != 32'd0)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (ofs == POS_BITS'(OFS_LAST))
                    begin
                        if (prg_reg != 8'd0 && prg_reg < PRG_LIMIT)
                        begin
                            found_start_next = cand_start_reg;
                            found_end_next   = cand_start_reg + POS_BITS'(span_reg);
                            phase_next       = PH_FOUND;
                            accepted         = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (ofs == POS_BITS'(OFS_MAGIC) || ofs > POS_BITS'(OFS_LAST))
                    begin
                        // a block jump moved us off the header
                        phase_next = PH_IDLE;
                    end
                end
                PH_FOUND:
                begin
                    phase_next = PH_FOUND;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // keep the end offset ready for the last header byte
        span_next = span_calc(prg_next, chr_next);

        if (short_block)
        begin
            result.status = ST_DISABLED;
        end
        else if (accepted)
        begin
            result.status = ST_ACCEPT;
        end
        else if (phase_next != PH_IDLE)
        begin
            result.status = ST_BUSY;
        end
        else
        begin
            result.status = ST_IDLE;
        end
        result.rom_start = 32'(found_start_next);
        result.rom_end   = 32'(found_end_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= '0;
            phase_reg       <= PH_IDLE;
            magic_pos_reg   <= '0;
            prg_reg         <= '0;
            chr_reg         <= '0;
            stream_pos_reg  <= '0;
            block_start_reg <= '0;
            cand_start_reg  <= '0;
            span_reg        <= '0;
            found_start_reg <= '0;
            found_end_reg   <= '0;
        end
        else if (fire)
        begin
            window_reg      <= window_next;
            phase_reg       <= phase_next;
            magic_pos_reg   <= magic_pos_next;
            prg_reg         <= prg_next;
            chr_reg         <= chr_next;
            stream_pos_reg  <= stream_pos_next;
            block_start_reg <= block_start_next;
            cand_start_reg  <= cand_start_next;
            span_reg        <= span_next;
            found_start_reg <= found_start_next;
            found_end_reg   <= found_end_next;
        end
    end

    `IRHD_ASSERT_IMPL(a_accept_from_header, fire && result.status == ST_ACCEPT, phase_reg == PH_HEADER)
    `IRHD_ASSERT_NEXT(a_accept_to_found, fire && result.status == ST_ACCEPT, phase_reg == PH_FOUND)
    `IRHD_ASSERT_NEXT(a_found_sticks, phase_reg == PH_FOUND, phase_reg == PH_FOUND)
    `IRHD_ASSERT_NEXT(a_short_no_step, fire && short_block, $stable(stream_pos_reg) && $stable(window_reg))

endmodule

/* src/irhd_out_stage.sv */
// result register of the header detector, holds one result until taken
// depends on irhd_pkg and irhd_if
module irhd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  irhd_pkg::result_t result_in,
    output logic              free,
    irhd_result_if.source     result
);
    import irhd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (fire)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_in;
        end
    end

    assign result.valid = valid_reg;
    assign result.data  = result_reg;

endmodule

/* src/ines_rom_header_detector_unit.sv */
// ines rom header detector: top level, input register, scan logic, result register
// depends on irhd_pkg, irhd_if, irhd_in_stage, irhd_scan, irhd_out_stage
//
//   channel   dir   payload                                  accepted when
//   stream    in    data_byte, block_pos, block_len          valid && ready
//   result    out   status, rom_start, rom_end               valid && ready
//
// one item per cycle sustained unless the result is stalled; each item is held in
// the input register, then scanned and written into the result register
// the scan state updates once per item in a single pass, set by the position subtract
// rst_n clears the scan state to idle at once; no clearing pass
// a stalled result holds the scanner; the input register then fills and drops ready
module ines_rom_header_detector_unit #(
    parameter int unsigned POS_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    irhd_item_if.sink     stream,
    irhd_result_if.source result
);
    import irhd_pkg::*;

    logic    item_valid;
    item_t   item;
    logic    out_free;
    logic    fire;
    result_t scan_result;

    assign fire = item_valid && out_free;

    irhd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .advance    (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    irhd_scan #(
        .POS_BITS (POS_BITS)
    ) u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (scan_result)
    );

    irhd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .result_in (scan_result),
        .free      (out_free),
        .result    (result)
    );

endmodule

/* tb/sv/ines_rom_header_detector_unit_tb.sv */
// self-checking testbench for the ines rom header detector
// depends on irhd_pkg, irhd_if and the ines_rom_header_detector_unit rtl
module ines_rom_header_detector_unit_tb;

    import irhd_pkg::*;

    localparam int          DIR_N        = 21;
    localparam int          RAND_ITEMS   = 730;
    localparam int          LONG_HOLD    = 120;
    localparam int          DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef enum logic [2:0] {
        HDR_BAD_PRG,
        HDR_BAD_FLAGS,
        HDR_BAD_PAD,
        HDR_JUMP_OUT,
        HDR_JUMP_IN,
        HDR_GOOD
    } hdr_kind_t;

    typedef struct packed {
        logic [7:0]  b;
        logic [31:0] bp;
        logic [31:0] bl;
        logic        chk;
        status_t     st;
        logic [31:0] rs;
        logic [31:0] re;
    } dir_row_t;

    logic clk;
    logic rst_n;

    irhd_item_if   byte_ch ();
    irhd_result_if span_ch ();

    ines_rom_header_detector_unit #(
        .POS_BITS(32)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .stream(byte_ch),
        .result(span_ch)
    );

    // directed items; chk rows carry an expected response typed in by hand
    dir_row_t dir_tab [DIR_N] = '{
        '{8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_DISABLED, 32'h0, 32'h0},
        '{8'hFF, 32'h0000_0000, 32'h0000_400E, 1'b1, ST_DISABLED, 32'h0, 32'h0},
        '{8'hFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_IDLE,     32'h0, 32'h0},
        '{8'h4E, 32'h0000_0000, 32'h0000_400F, 1'b1, ST_IDLE,     32'h0, 32'h0},
        '{8'h45, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_IDLE,     32'h0, 32'h0},
        '{8'h53, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_IDLE,     32'h0, 32'h0},
        '{8'h1A, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_BUSY,     32'h0, 32'h0},
        '{8'h80, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_BUSY,     32'h0, 32'h0},
        '{8'hFF, 32'h0000_0000, 32'h8000_0000, 1'b0, ST_IDLE,     32'h0, 32'h0},
        '{8'h00, 32'h0000_0000, 32'h0001_0000, 1'b0, ST_IDLE,     32'h0, 32'h0},
        '{8'hA5, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ST_IDLE,     32'h0, 32'h0},
        '{8'h5A, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ST_IDLE,     32'h0, 32'h0},
        '{8'h02, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_IDLE,     32'h0, 32'h0},
        '{8'h4E, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ST_IDLE,     32'h0, 32'h0},
        '{8'h45, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ST_IDLE,     32'h0, 32'h0},
        '{8'h53, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ST_IDLE,     32'h0, 32'h0},
        '{8'h1A, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_BUSY,     32'h0, 32'h0},
        '{8'h01, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ST_IDLE,     32'h0, 32'h0},
        '{8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ST_IDLE,     32'h0, 32'h0},
        '{8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_IDLE,     32'h0, 32'h0},
        '{8'hFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, ST_IDLE,     32'h0, 32'h0}
    };

    // stimulus, built before reset
    item_t   stim_q  [$];
    bit      chk_q   [$];
    result_t typed_q [$];
    bit      hold_q  [$];
    bit      pause_next;
    logic [31:0] gen_bp;
    logic [31:0] gen_pos;

    // expected detector responses, oldest first
    result_t resp_q [$];
    int      acc_n = 0;
    int      res_n = 0;
    int      bad_cnt = 0;
    int unsigned cyc = 0;

    // scanner state as the detector should hold it
    logic [31:0] win_q        = '0;
    phase_t      ph_q         = PH_IDLE;
    logic [31:0] magic_pos_q  = '0;
    logic [7:0]  prg_q        = '0;
    logic [7:0]  chr_q        = '0;
    logic [31:0] stream_pos_q = '0;
    logic [31:0] blk_start_q  = '0;
    logic [31:0] rom_start_q  = '0;
    logic [31:0] rom_end_q    = '0;

    function automatic result_t scan_byte(input item_t it);
        result_t     r;
        logic [31:0] ofs;
        logic        hit;
        hit = 1'b0;
        if (it.block_pos == '0 && it.block_len < MIN_FIRST_LEN)
        begin
            r.status = ST_DISABLED;
        end
        else
        begin
            if (it.block_pos != blk_start_q)
            begin
                blk_start_q  = it.block_pos;
                stream_pos_q = it.block_pos;
            end
            win_q = {win_q[23:0], it.data_byte};
            ofs   = stream_pos_q - magic_pos_q;
            if (ph_q == PH_IDLE && win_q == MAGIC_WORD)
            begin
                ph_q        = PH_HEADER;
                magic_pos_q = stream_pos_q;
                prg_q       = '0;
            end
            else if (ph_q == PH_HEADER)
            begin
                case (ofs)
                    OFS_MAGIC: ph_q = PH_IDLE;
                    OFS_PRG:   prg_q = it.data_byte;
                    OFS_CHR:   chr_q = it.data_byte;
                    OFS_FLAGS:
                    begin
                        if ((win_q[7:0] & FLAG_MASK) != '0)
                            ph_q = PH_IDLE;
                    end
                    OFS_PAD:
                    begin
                        if (win_q != '0)
                            ph_q = PH_IDLE;
                    end
                    OFS_LAST:
                    begin
                        if (prg_q != '0 && prg_q < PRG_LIMIT)
                        begin
                            rom_start_q = magic_pos_q - 32'(START_BACK);
                            rom_end_q   = rom_start_q + 32'(prg_q) * 32'(PRG_FACTOR)
                                        + 32'(chr_q) * 32'(CHR_FACTOR) + 32'(END_EXTRA);
                            ph_q        = PH_FOUND;
                            hit         = 1'b1;
                        end
                        else
                        begin
                            ph_q = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        if (ofs > 32'(OFS_LAST))
                            ph_q = PH_IDLE;
                    end
                endcase
            end
            stream_pos_q = stream_pos_q + 32'd1;
            if (hit)
                r.status = ST_ACCEPT;
            else if (ph_q != PH_IDLE)
                r.status = ST_BUSY;
            else
                r.status = ST_IDLE;
        end
        r.rom_start = rom_start_q;
        r.rom_end   = rom_end_q;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [31:0] pick_len(input logic [31:0] bp);
        logic [31:0] len;
        len = $urandom;
        // keep the block at position zero long enough to be scanned
        if (bp == '0 && len < MIN_FIRST_LEN)
            len = len + MIN_FIRST_LEN;
        return len;
    endfunction

    function automatic logic [7:0] pick_prg(input bit ok);
        if (ok)
        begin
            case ($urandom_range(0, 3))
                0:       return 8'd1;
                1:       return 8'd128;
                default: return 8'($urandom_range(1, 128));
            endcase
        end
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return PRG_LIMIT;
            2:       return 8'hFF;
            default: return 8'($urandom_range(129, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_chr();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic note_err(input string msg);
        bad_cnt++;
        if (bad_cnt <= 10)
            $display("%s", msg);
    endtask

    // queues an item and tracks the stream position the detector will see
    task automatic push_item(input item_t it, input bit chk, input result_t ex);
        stim_q.push_back(it);
        chk_q.push_back(chk);
        typed_q.push_back(ex);
        hold_q.push_back(pause_next);
        pause_next = 1'b0;
        if (!(it.block_pos == '0 && it.block_len < MIN_FIRST_LEN))
        begin
            if (it.block_pos != gen_bp)
            begin
                gen_bp  = it.block_pos;
                gen_pos = it.block_pos;
            end
            gen_pos = gen_pos + 32'd1;
        end
    endtask

    task automatic push_jump(input logic [7:0] b, input logic [31:0] bp);
        item_t it;
        if (bp == gen_bp)
            bp = bp + 32'd1000;
        it.data_byte = b;
        it.block_pos = bp;
        it.block_len = pick_len(bp);
        push_item(it, 1'b0, '0);
    endtask

    task automatic push_byte(input logic [7:0] b);
        item_t it;
        it.data_byte = b;
        it.block_pos = gen_bp;
        it.block_len = pick_len(gen_bp);
        push_item(it, 1'b0, '0);
    endtask

    task automatic push_short();
        item_t it;
        it.data_byte = 8'($urandom_range(0, 255));
        it.block_pos = '0;
        it.block_len = $urandom_range(0, MIN_FIRST_LEN - 1);
        push_item(it, 1'b0, '0);
    endtask

    task automatic send_header(input hdr_kind_t kind);
        logic [7:0]  hb [16];
        logic [31:0] mpos;
        int          k;
        int          blip_at;
        hb[0]  = MAGIC_WORD[31:24];
        hb[1]  = MAGIC_WORD[23:16];
        hb[2]  = MAGIC_WORD[15:8];
        hb[3]  = MAGIC_WORD[7:0];
        hb[4]  = pick_prg(kind != HDR_BAD_PRG && kind != HDR_JUMP_IN);
        hb[5]  = pick_chr();
        hb[6]  = 8'($urandom_range(0, 255));
        hb[7]  = 8'($urandom_range(0, 255));
        hb[8]  = 8'($urandom_range(0, 255));
        hb[9]  = (kind == HDR_BAD_FLAGS) ? 8'($urandom_range(2, 255))
                                         : 8'($urandom_range(0, 1));
        hb[10] = 8'($urandom_range(0, 255));
        hb[11] = 8'h00;
        hb[12] = 8'h00;
        hb[13] = 8'h00;
        hb[14] = 8'h00;
        hb[15] = 8'($urandom_range(0, 255));
        if (kind == HDR_BAD_PAD)
            hb[11 + $urandom_range(0, 3)] = 8'($urandom_range(1, 255));
        case (kind)
            HDR_JUMP_OUT: k = $urandom_range(5, 15);
            HDR_JUMP_IN:  k = $urandom_range(5, 12);
            default:      k = -1;
        endcase
        // a short first-block item in the middle must leave the header untouched
        blip_at = (kind != HDR_GOOD && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : -1;
        mpos = gen_pos + 32'd3;
        for (int i = 0; i < 16; i++)
        begin
            if (i == blip_at)
                push_short();
            if (i == k && kind == HDR_JUMP_OUT)
                push_jump(hb[i], $urandom_range(0, 1) ? mpos
                                 : mpos + 32'd13 + 32'($urandom_range(0, 5000)));
            else if (i == k)
                push_jump(hb[i], gen_pos + 32'($urandom_range(1, 2)));
            else
                push_byte(hb[i]);
        end
    endtask

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 19))
                0: push_short();
                1: push_jump(8'($urandom_range(0, 255)), $urandom);
                2: push_jump(8'($urandom_range(0, 255)), '0);
                3:
                begin
                    // magic cut short
                    push_byte(MAGIC_WORD[31:24]);
                    push_byte(MAGIC_WORD[23:16]);
                    push_byte(MAGIC_WORD[15:8]);
                end
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic build_stimulus();
        item_t   it;
        result_t ex;
        int      next_pause;
        gen_bp     = '0;
        gen_pos    = '0;
        pause_next = 1'b0;
        foreach (dir_tab[n])
        begin
            it.data_byte = dir_tab[n].b;
            it.block_pos = dir_tab[n].bp;
            it.block_len = dir_tab[n].bl;
            ex.status    = dir_tab[n].st;
            ex.rom_start = dir_tab[n].rs;
            ex.rom_end   = dir_tab[n].re;
            push_item(it, dir_tab[n].chk, ex);
        end
        pause_next = 1'b1;
        next_pause = DIR_N + 250;
        while (stim_q.size() < DIR_N + RAND_ITEMS)
        begin
            if ($urandom_range(0, 99) < 55)
                send_header(hdr_kind_t'($urandom_range(0, 4)));
            else
                send_noise($urandom_range(1, 12));
            if (stim_q.size() > next_pause)
            begin
                pause_next = 1'b1;
                next_pause += 250;
            end
        end
        // the one accepted header, possibly across the position wrap
        pause_next = 1'b1;
        case ($urandom_range(0, 2))
            0:       push_jump(8'($urandom_range(0, 255)), 32'hFFFF_FFFF - $urandom_range(0, 6));
            1:       push_jump(8'($urandom_range(0, 255)), $urandom);
            default: push_byte(8'($urandom_range(0, 255)));
        endcase
        send_header(HDR_GOOD);
        send_noise(4);
        send_header(HDR_GOOD);
        send_noise(4);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cyc <= cyc + 1;

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("ines_rom_header_detector_unit_tb: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin : watch
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (span_ch.valid && span_ch.ready)
            begin
                got = span_ch.data;
                if (resp_q.size() == 0)
                begin
                    note_err($sformatf("result %0d arrived with nothing expected: %0h",
                                       res_n, got));
                end
                else
                begin
                    want = resp_q.pop_front();
                    if (got.status !== want.status)
                        note_err($sformatf("result %0d status: expected %0d got %0d",
                                           res_n, want.status, got.status));
                    if (got.rom_start !== want.rom_start)
                        note_err($sformatf("result %0d rom_start: expected %0h got %0h",
                                           res_n, want.rom_start, got.rom_start));
                    if (got.rom_end !== want.rom_end)
                        note_err($sformatf("result %0d rom_end: expected %0h got %0h",
                                           res_n, want.rom_end, got.rom_end));
                end
                res_n++;
            end
            if (byte_ch.valid && byte_ch.ready)
            begin
                want = scan_byte(byte_ch.data);
                if (chk_q[acc_n])
                    want = typed_q[acc_n];
                resp_q.push_back(want);
                acc_n++;
            end
        end
    end

    // result side: random stalls, a quiet stretch now and then, three long holds
    initial
    begin : result_side
        int hold_left;
        int seen;
        int long_at;
        hold_left = 0;
        seen      = 0;
        long_at   = 150;
        span_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (span_ch.valid && span_ch.ready)
                seen++;
            if (hold_left > 0)
            begin
                hold_left--;
                span_ch.ready <= 1'b0;
            end
            else if (seen >= long_at)
            begin
                long_at += 300;
                hold_left = LONG_HOLD;
                span_ch.ready <= 1'b0;
            end
            else if (cyc[9:8] == 2'b10)
            begin
                span_ch.ready <= 1'b1;
            end
            else
            begin
                hold_left = pick_gap();
                span_ch.ready <= (hold_left == 0);
            end
        end
    end

    initial
    begin : byte_side
        int unsigned gap;
        rst_n         <= 1'b0;
        byte_ch.valid <= 1'b0;
        byte_ch.data  <= '0;
        build_stimulus();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < stim_q.size(); i++)
        begin
            gap = ((i / 64) % 4 == 1) ? 0 : pick_gap();
            if (hold_q[i] && gap == 0)
                gap = 1;
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
                // let the detector drain completely before this item
                if (hold_q[i])
                    while (resp_q.size() != 0) @(posedge clk);
            end
            byte_ch.valid <= 1'b1;
            byte_ch.data  <= stim_q[i];
            @(posedge clk);
            while (!byte_ch.ready) @(posedge clk);
        end
        byte_ch.valid <= 1'b0;
        while (resp_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_cnt == 0 && resp_q.size() == 0)
            $display("ines_rom_header_detector_unit_tb: done, clean");
        else
            $display("ines_rom_header_detector_unit_tb: done, errors");
        $finish;
    end

endmodule
